// ===== hdl/triangle_edge_rasterizer_assert.svh =====
// Assertion macros for the triangle edge rasterizer
`ifndef TRIANGLE_EDGE_RASTERIZER_ASSERT_SVH
`define TRIANGLE_EDGE_RASTERIZER_ASSERT_SVH

`ifndef SYNTH
`define TER_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TER_ASSERT(lbl, prop, msg) `TER_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)
`else
`define TER_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define TER_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== hdl/ter_pkg.sv =====
// Shared constants, types and helpers for the triangle edge rasterizer
package ter_pkg;

    localparam int IMAGE_WIDTH     = 256;
    localparam int BYTES_PER_PIXEL = 3;
    localparam int CHUNK_PIXELS    = 32;   // power of two
    localparam int MAX_RESULTS     = 8;
    localparam int NUM_EDGES       = 3;

    localparam int CW         = 8;    // coordinate width
    localparam int DW         = CW + 1;
    localparam int EW         = 20;   // edge function accumulator
    localparam int XW         = 10;   // pixel x inside the cell row
    localparam int AFW        = 26;   // full byte address before truncation
    localparam int ADDR_W     = 18;
    localparam int COLOR_W    = 24;
    localparam int MASK_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int CNT_W      = $clog2(MAX_RESULTS);
    localparam int SETTLE_W   = $clog2(CHUNK_PIXELS + 1);

    localparam logic [CW-1:0] CHUNK_ALIGN = ~CW'(CHUNK_PIXELS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A_X,
        REG_A_Y,
        REG_B_X,
        REG_B_Y,
        REG_C_X,
        REG_C_Y,
        REG_FILL
    } ter_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_BASE,
        ST_LOAD,
        ST_RUN
    } ter_state_t;

    typedef logic [EW-1:0] edge_val_t;
    typedef edge_val_t [NUM_EDGES-1:0] edge_vec_t;

    // data handed from one cell to its right neighbor
    typedef struct packed {
        logic [XW-1:0] xoff;
        edge_vec_t     eoff;
    } ter_link_t;

    typedef struct packed {
        logic capture;
        logic mul_en;
        logic base_en;
        logic load;
        logic step;
        logic last;
    } ter_ctrl_t;

    function automatic logic [CW-1:0] min3(input logic [CW-1:0] p, input logic [CW-1:0] q,
                                           input logic [CW-1:0] r);
        logic [CW-1:0] m;
        m = (p < q) ? p : q;
        return (m < r) ? m : r;
    endfunction

    function automatic logic [CW-1:0] max3(input logic [CW-1:0] p, input logic [CW-1:0] q,
                                           input logic [CW-1:0] r);
        logic [CW-1:0] m;
        m = (p > q) ? p : q;
        return (m > r) ? m : r;
    endfunction

endpackage

// ===== hdl/ter_cell.sv =====
// One pixel cell: edge offsets chain, edge accumulators and coverage test
module ter_cell (
    input  logic                         aclk,
    input  ter_pkg::ter_link_t           left_i,
    output ter_pkg::ter_link_t           right_o,
    input  ter_pkg::edge_vec_t           a_i,
    input  ter_pkg::edge_vec_t           base_i,
    input  ter_pkg::edge_vec_t           step_i,
    input  ter_pkg::ter_ctrl_t           ctrl_i,
    input  logic [ter_pkg::CW-1:0]       start_i,
    input  logic [ter_pkg::CW-1:0]       box_min_i,
    input  logic [ter_pkg::CW-1:0]       box_max_i,
    output logic                         cov_o
);

    logic [ter_pkg::XW-1:0] xoff_reg;
    ter_pkg::edge_vec_t     eoff_reg;
    ter_pkg::edge_vec_t     e_reg;
    ter_pkg::edge_vec_t     e_next;
    logic [ter_pkg::XW-1:0] x_reg;
    logic [ter_pkg::XW-1:0] x_next;
    logic                   in_box;
    logic                   all_pos;

    // offset chain: this cell sits one pixel right of its neighbor
    always_ff @(posedge aclk) begin
        xoff_reg <= left_i.xoff + ter_pkg::XW'(1);
        for (int k = 0; k < ter_pkg::NUM_EDGES; k++) begin
            eoff_reg[k] <= left_i.eoff[k] + a_i[k];
        end
    end

    assign right_o.xoff = xoff_reg;
    assign right_o.eoff = eoff_reg;

    always_comb begin
        e_next = e_reg;
        x_next = x_reg;
        if (ctrl_i.load) begin
            x_next = ter_pkg::XW'(start_i) + xoff_reg;
            for (int k = 0; k < ter_pkg::NUM_EDGES; k++) begin
                e_next[k] = base_i[k] + eoff_reg[k];
            end
        end else if (ctrl_i.step) begin
            x_next = x_reg + ter_pkg::XW'(ter_pkg::CHUNK_PIXELS);
            for (int k = 0; k < ter_pkg::NUM_EDGES; k++) begin
                e_next[k] = e_reg[k] + step_i[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        e_reg <= e_next;
        x_reg <= x_next;
    end

    always_comb begin
        all_pos = 1'b1;
        for (int k = 0; k < ter_pkg::NUM_EDGES; k++) begin
            all_pos = all_pos & ~e_reg[k][ter_pkg::EW-1];
        end
    end

    assign in_box = (x_reg >= ter_pkg::XW'(box_min_i)) && (x_reg <= ter_pkg::XW'(box_max_i));
    assign cov_o  = in_box && all_pos;

endmodule

// ===== hdl/ter_ctrl.sv =====
// Row sequencer: setup steps, chunk counting and handshake control
module ter_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               busy_i,
    input  logic               out_free_i,
    input  logic               x_end_i,
    output ter_pkg::ter_ctrl_t ctrl_o
);

    ter_pkg::ter_state_t       state_reg;
    ter_pkg::ter_state_t       state_next;
    logic [ter_pkg::CNT_W-1:0] cnt_reg;
    logic                      last;

    assign last = x_end_i || (cnt_reg == ter_pkg::CNT_W'(ter_pkg::MAX_RESULTS - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ter_pkg::ST_IDLE: begin
                if (s_valid && !busy_i) begin
                    state_next = ter_pkg::ST_MUL;
                end
            end
            ter_pkg::ST_MUL:  state_next = ter_pkg::ST_BASE;
            ter_pkg::ST_BASE: state_next = ter_pkg::ST_LOAD;
            ter_pkg::ST_LOAD: state_next = ter_pkg::ST_RUN;
            ter_pkg::ST_RUN: begin
                if (out_free_i && last) begin
                    state_next = ter_pkg::ST_IDLE;
                end
            end
            default: state_next = ter_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl_o      = '0;
        ctrl_o.last = last;
        s_ready     = 1'b0;
        unique case (state_reg)
            ter_pkg::ST_IDLE: begin
                s_ready        = !busy_i;
                ctrl_o.capture = s_valid && !busy_i;
            end
            ter_pkg::ST_MUL:  ctrl_o.mul_en  = 1'b1;
            ter_pkg::ST_BASE: ctrl_o.base_en = 1'b1;
            ter_pkg::ST_LOAD: ctrl_o.load    = 1'b1;
            ter_pkg::ST_RUN:  ctrl_o.step    = out_free_i;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ter_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (ctrl_o.load) begin
                cnt_reg <= '0;
            end else if (ctrl_o.step) begin
                cnt_reg <= cnt_reg + ter_pkg::CNT_W'(1);
            end
        end
    end

endmodule

// ===== hdl/triangle_edge_rasterizer.sv =====
// Top level: configuration, row setup, pixel cell row and result register
//
//  channel   dir  handshake           payload
//  s_        in   s_valid / s_ready   s_row_y
//  m_        out  m_valid / m_ready   m_out_row, m_chunk_x, m_coverage_mask,
//                                     m_pixel_address, m_out_color, m_last_chunk
//  cfg_      in   cfg_wr_en           cfg_index, cfg_wr_data
//
// A row gives n results (1..8): transfer, product stage, base stage, cell load,
// then one chunk mask per cycle while m_ready allows, from the row of CHUNK_PIXELS cells.
// The offset chain through the cells must settle after reset and after every
// register write; s_ready stays low meanwhile.
// A stalled m_ready holds the chunk walk; the next row is taken while the last
// result of the previous row waits.
`include "triangle_edge_rasterizer_assert.svh"

module triangle_edge_rasterizer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [ter_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ter_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ter_pkg::CW-1:0]            s_row_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ter_pkg::CW-1:0]            m_out_row,
    output logic [ter_pkg::CW-1:0]            m_chunk_x,
    output logic [ter_pkg::MASK_W-1:0]        m_coverage_mask,
    output logic [ter_pkg::ADDR_W-1:0]        m_pixel_address,
    output logic [ter_pkg::COLOR_W-1:0]       m_out_color,
    output logic                              m_last_chunk
);

    localparam int NE = ter_pkg::NUM_EDGES;
    localparam int NC = ter_pkg::CHUNK_PIXELS;

    logic [ter_pkg::CW-1:0]       vx_reg [NE];
    logic [ter_pkg::CW-1:0]       vy_reg [NE];
    logic [ter_pkg::COLOR_W-1:0]  fill_reg;
    logic [ter_pkg::CW-1:0]       box_min_x_reg, box_max_x_reg;
    logic [ter_pkg::CW-1:0]       box_min_y_reg, box_max_y_reg;
    logic [ter_pkg::SETTLE_W-1:0] settle_reg;

    logic [ter_pkg::CW-1:0]       y_reg;
    logic [ter_pkg::CW-1:0]       start_reg;
    logic                         in_box_reg;
    ter_pkg::edge_vec_t           p1_reg, p2_reg, base_reg;
    logic [ter_pkg::AFW-1:0]      row_addr_reg;
    logic [ter_pkg::AFW-1:0]      addr_reg;
    logic [ter_pkg::XW-1:0]       x0_reg;

    logic                         out_valid_reg;
    logic [ter_pkg::CW-1:0]       out_row_reg;
    logic [ter_pkg::XW-1:0]       out_x_reg;
    logic [ter_pkg::MASK_W-1:0]   out_mask_reg;
    logic [ter_pkg::AFW-1:0]      out_addr_reg;
    logic [ter_pkg::COLOR_W-1:0]  out_color_reg;
    logic                         out_last_reg;

    logic [ter_pkg::CW-1:0]       start_x;
    ter_pkg::edge_vec_t           a_vec, step_vec, head_eoff;
    ter_pkg::edge_vec_t           p1_next, p2_next;
    ter_pkg::ter_link_t           link [NC];
    logic [NC-1:0]                cov;
    logic [ter_pkg::MASK_W-1:0]   mask_full;
    ter_pkg::ter_ctrl_t           ctrl;
    logic                         out_free;
    logic                         x_end;
    logic                         empty_row;

    // configuration and bounding box
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NE; k++) begin
                vx_reg[k] <= '0;
                vy_reg[k] <= '0;
            end
            fill_reg      <= '0;
            box_min_x_reg <= '0;
            box_max_x_reg <= '0;
            box_min_y_reg <= '0;
            box_max_y_reg <= '0;
            settle_reg    <= ter_pkg::SETTLE_W'(NC);
        end else begin
            box_min_x_reg <= ter_pkg::min3(vx_reg[0], vx_reg[1], vx_reg[2]);
            box_max_x_reg <= ter_pkg::max3(vx_reg[0], vx_reg[1], vx_reg[2]);
            box_min_y_reg <= ter_pkg::min3(vy_reg[0], vy_reg[1], vy_reg[2]);
            box_max_y_reg <= ter_pkg::max3(vy_reg[0], vy_reg[1], vy_reg[2]);
            if (cfg_wr_en) begin
                settle_reg <= ter_pkg::SETTLE_W'(NC);
                unique case (cfg_index)
                    ter_pkg::REG_A_X:  vx_reg[0] <= cfg_wr_data[ter_pkg::CW-1:0];
                    ter_pkg::REG_A_Y:  vy_reg[0] <= cfg_wr_data[ter_pkg::CW-1:0];
                    ter_pkg::REG_B_X:  vx_reg[1] <= cfg_wr_data[ter_pkg::CW-1:0];
                    ter_pkg::REG_B_Y:  vy_reg[1] <= cfg_wr_data[ter_pkg::CW-1:0];
                    ter_pkg::REG_C_X:  vx_reg[2] <= cfg_wr_data[ter_pkg::CW-1:0];
                    ter_pkg::REG_C_Y:  vy_reg[2] <= cfg_wr_data[ter_pkg::CW-1:0];
                    ter_pkg::REG_FILL: fill_reg  <= cfg_wr_data[ter_pkg::COLOR_W-1:0];
                    default: ;
                endcase
            end else if (settle_reg != '0) begin
                settle_reg <= settle_reg - ter_pkg::SETTLE_W'(1);
            end
        end
    end

    assign start_x = box_min_x_reg & ter_pkg::CHUNK_ALIGN;

    // edge coefficients: E = A*(px-ux) - D*(py-uy), A = vy-uy, D = vx-ux
    for (genvar k = 0; k < NE; k++) begin : g_edge
        localparam int V = (k + 1) % NE;
        logic signed [ter_pkg::DW-1:0] dy_s, dx_s, sx_s, ry_s;
        logic signed [ter_pkg::EW-1:0] p1_s, p2_s;

        assign dy_s = ter_pkg::DW'(vy_reg[V]) - ter_pkg::DW'(vy_reg[k]);
        assign dx_s = ter_pkg::DW'(vx_reg[V]) - ter_pkg::DW'(vx_reg[k]);
        assign sx_s = ter_pkg::DW'(start_x) - ter_pkg::DW'(vx_reg[k]);
        assign ry_s = ter_pkg::DW'(y_reg) - ter_pkg::DW'(vy_reg[k]);
        assign p1_s = ter_pkg::EW'(dy_s) * ter_pkg::EW'(sx_s);
        assign p2_s = ter_pkg::EW'(dx_s) * ter_pkg::EW'(ry_s);

        assign a_vec[k]     = ter_pkg::EW'(dy_s);
        assign step_vec[k]  = a_vec[k] * ter_pkg::EW'(NC);
        assign head_eoff[k] = ter_pkg::EW'(0) - a_vec[k];
        assign p1_next[k]   = p1_s;
        assign p2_next[k]   = p2_s;
    end

    // row setup pipeline
    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            y_reg <= s_row_y;
        end
        if (ctrl.mul_en) begin
            p1_reg       <= p1_next;
            p2_reg       <= p2_next;
            start_reg    <= start_x;
            in_box_reg   <= (y_reg >= box_min_y_reg) && (y_reg <= box_max_y_reg);
            row_addr_reg <= ter_pkg::AFW'(y_reg) *
                            ter_pkg::AFW'(ter_pkg::IMAGE_WIDTH * ter_pkg::BYTES_PER_PIXEL);
        end
        if (ctrl.base_en) begin
            for (int k = 0; k < NE; k++) begin
                base_reg[k] <= p1_reg[k] - p2_reg[k];
            end
            addr_reg <= in_box_reg ?
                        row_addr_reg + ter_pkg::AFW'(start_reg) *
                                       ter_pkg::AFW'(ter_pkg::BYTES_PER_PIXEL) :
                        row_addr_reg;
        end else if (ctrl.step) begin
            addr_reg <= addr_reg + ter_pkg::AFW'(NC * ter_pkg::BYTES_PER_PIXEL);
        end
        if (ctrl.load) begin
            x0_reg <= in_box_reg ? ter_pkg::XW'(start_reg) : '0;
        end else if (ctrl.step) begin
            x0_reg <= x0_reg + ter_pkg::XW'(NC);
        end
    end

    assign empty_row = !in_box_reg;
    assign x_end     = empty_row ||
                       ((x0_reg + ter_pkg::XW'(NC)) > ter_pkg::XW'(box_max_x_reg));

    // row of pixel cells
    assign link[0].xoff = '1;
    assign link[0].eoff = head_eoff;

    for (genvar i = 0; i < NC; i++) begin : g_cell
        if (i < NC - 1) begin : g_mid
            ter_cell u_cell (
                .aclk      (aclk),
                .left_i    (link[i]),
                .right_o   (link[i+1]),
                .a_i       (a_vec),
                .base_i    (base_reg),
                .step_i    (step_vec),
                .ctrl_i    (ctrl),
                .start_i   (start_reg),
                .box_min_i (box_min_x_reg),
                .box_max_i (box_max_x_reg),
                .cov_o     (cov[i])
            );
        end else begin : g_end
            ter_cell u_cell (
                .aclk      (aclk),
                .left_i    (link[i]),
                .right_o   (),
                .a_i       (a_vec),
                .base_i    (base_reg),
                .step_i    (step_vec),
                .ctrl_i    (ctrl),
                .start_i   (start_reg),
                .box_min_i (box_min_x_reg),
                .box_max_i (box_max_x_reg),
                .cov_o     (cov[i])
            );
        end
    end

    for (genvar b = 0; b < ter_pkg::MASK_W; b++) begin : g_mask
        if (b < NC) begin : g_bit
            assign mask_full[b] = cov[b];
        end else begin : g_zero
            assign mask_full[b] = 1'b0;
        end
    end

    ter_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .busy_i     (settle_reg != '0),
        .out_free_i (out_free),
        .x_end_i    (x_end),
        .ctrl_o     (ctrl)
    );

    // result register
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.step) begin
            out_row_reg   <= y_reg;
            out_x_reg     <= x0_reg;
            out_mask_reg  <= empty_row ? '0 : mask_full;
            out_addr_reg  <= addr_reg;
            out_color_reg <= fill_reg;
            out_last_reg  <= ctrl.last;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_out_row       = out_row_reg;
    assign m_chunk_x       = out_x_reg[ter_pkg::CW-1:0];
    assign m_coverage_mask = out_mask_reg;
    assign m_pixel_address = out_addr_reg[ter_pkg::ADDR_W-1:0];
    assign m_out_color     = out_color_reg;
    assign m_last_chunk    = out_last_reg;

    `TER_ASSERT(a_settle_blocks_input, (settle_reg != '0) |-> !s_ready, "transfer taken while cells settle")
    `TER_ASSERT(a_more_chunks_follow, (m_valid && !m_last_chunk) |-> ((out_x_reg + ter_pkg::XW'(NC)) <= ter_pkg::XW'(box_max_x_reg)), "non-last chunk at end of box")
    `TER_ASSERT(a_row_ends_last, (ctrl.step && ctrl.last) |=> (m_valid && m_last_chunk), "row finished without last flag")

endmodule

// ===== verif/testbench.sv =====
// Testbench for triangle_edge_rasterizer: directed and random scanlines checked against a row predictor
module testbench;
    import ter_pkg::*;

    typedef struct packed {
        logic [CW-1:0]      row;
        logic [CW-1:0]      x;
        logic [MASK_W-1:0]  mask;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               last;
    } chunk_t;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_TRIANGLES = 10;
    localparam int ROWS_PER_TRIANGLE = 33;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CW-1:0] s_row_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [CW-1:0] m_out_row;
    logic [CW-1:0] m_chunk_x;
    logic [MASK_W-1:0] m_coverage_mask;
    logic [ADDR_W-1:0] m_pixel_address;
    logic [COLOR_W-1:0] m_out_color;
    logic m_last_chunk;

    triangle_edge_rasterizer i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_row_y         (s_row_y),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_row       (m_out_row),
        .m_chunk_x       (m_chunk_x),
        .m_coverage_mask (m_coverage_mask),
        .m_pixel_address (m_pixel_address),
        .m_out_color     (m_out_color),
        .m_last_chunk    (m_last_chunk)
    );

    always #4 aclk = ~aclk;

    logic [CW-1:0] vert_x[3];
    logic [CW-1:0] vert_y[3];
    logic [COLOR_W-1:0] fill_rgb;

    logic [CW-1:0] row_q[$];
    chunk_t expected_chunks[$];
    int rows_open = 0;
    int mismatch_count = 0;
    int send_gap = 0;
    int ready_gap = 0;
    int quiet_cycles = 0;
    bit calm = 1'b0;

    initial begin
        vert_x = '{default: '0};
        vert_y = '{default: '0};
        fill_rgb = '0;
    end

    function automatic int edge_fn(input int ux, input int uy, input int vx, input int vy,
                                   input int px, input int py);
        return (px - ux) * (vy - uy) - (py - uy) * (vx - ux);
    endfunction

    function automatic void predict_row(input logic [CW-1:0] y);
        int lo_x, hi_x, lo_y, hi_y, x0, px, n;
        logic [31:0] byte_addr;
        chunk_t c;
        lo_x = vert_x[0];
        hi_x = vert_x[0];
        lo_y = vert_y[0];
        hi_y = vert_y[0];
        for (int k = 1; k < 3; k++) begin
            if (vert_x[k] < lo_x) lo_x = vert_x[k];
            if (vert_x[k] > hi_x) hi_x = vert_x[k];
            if (vert_y[k] < lo_y) lo_y = vert_y[k];
            if (vert_y[k] > hi_y) hi_y = vert_y[k];
        end
        if (y < lo_y || y > hi_y) begin
            byte_addr = IMAGE_WIDTH * y * BYTES_PER_PIXEL;
            c = '{row: y, x: '0, mask: '0, addr: byte_addr[ADDR_W-1:0], color: fill_rgb,
                  last: 1'b1};
            expected_chunks.push_back(c);
            return;
        end
        n = 0;
        for (x0 = (lo_x / CHUNK_PIXELS) * CHUNK_PIXELS; x0 <= hi_x && n < MAX_RESULTS;
             x0 += CHUNK_PIXELS) begin
            c.row = y;
            c.x = x0[CW-1:0];
            c.mask = '0;
            for (int i = 0; i < CHUNK_PIXELS && i < MASK_W; i++) begin
                px = x0 + i;
                if (px >= lo_x && px <= hi_x &&
                    edge_fn(vert_x[0], vert_y[0], vert_x[1], vert_y[1], px, y) >= 0 &&
                    edge_fn(vert_x[1], vert_y[1], vert_x[2], vert_y[2], px, y) >= 0 &&
                    edge_fn(vert_x[2], vert_y[2], vert_x[0], vert_y[0], px, y) >= 0)
                    c.mask[i] = 1'b1;
            end
            byte_addr = (IMAGE_WIDTH * y + x0) * BYTES_PER_PIXEL;
            c.addr = byte_addr[ADDR_W-1:0];
            c.color = fill_rgb;
            c.last = (x0 + CHUNK_PIXELS > hi_x) || (n == MAX_RESULTS - 1);
            expected_chunks.push_back(c);
            n++;
        end
    endfunction

    always @(posedge aclk) begin : row_driver
        logic nxt_valid;
        logic [CW-1:0] nxt_row;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            nxt_valid = s_valid;
            nxt_row = s_row_y;
            if (s_valid && s_ready) begin
                predict_row(s_row_y);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (row_q.size() > 0) begin
                    if (!calm && $urandom_range(0, 5) == 0) begin
                        send_gap = $urandom_range(0, 6);
                    end else begin
                        nxt_valid = 1'b1;
                        nxt_row = row_q.pop_front();
                    end
                end
            end
            s_valid <= nxt_valid;
            s_row_y <= nxt_row;
        end
    end

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : chunk_checker
        chunk_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_chunks.size() == 0) begin
                    $error("unexpected transfer: row %0d chunk_x %0d", m_out_row, m_chunk_x);
                    mismatch_count++;
                end else begin
                    want = expected_chunks.pop_front();
                    check_field("out_row", want.row, m_out_row);
                    check_field("chunk_x", want.x, m_chunk_x);
                    check_field("coverage_mask", want.mask, m_coverage_mask);
                    check_field("pixel_address", want.addr, m_pixel_address);
                    check_field("out_color", want.color, m_out_color);
                    check_field("last_chunk", want.last, m_last_chunk);
                    if (want.last) rows_open--;
                end
            end
            if (ready_gap > 0) begin
                ready_gap--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                ready_gap = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else if (aresetn) begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (ter_reg_t'(idx))
            REG_A_X: vert_x[0] = data[CW-1:0];
            REG_A_Y: vert_y[0] = data[CW-1:0];
            REG_B_X: vert_x[1] = data[CW-1:0];
            REG_B_Y: vert_y[1] = data[CW-1:0];
            REG_C_X: vert_x[2] = data[CW-1:0];
            REG_C_Y: vert_y[2] = data[CW-1:0];
            REG_FILL: fill_rgb = data[COLOR_W-1:0];
            default: ;
        endcase
    endtask

    // vertex writes carry random upper bits, which the block must ignore
    task automatic set_triangle(input logic [CW-1:0] ax, input logic [CW-1:0] ay,
                                input logic [CW-1:0] bx, input logic [CW-1:0] by,
                                input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                                input logic [COLOR_W-1:0] rgb);
        logic [CFG_DATA_W-1:0] noise;
        noise = CFG_DATA_W'($urandom);
        write_reg(REG_A_X, {noise[CFG_DATA_W-1:CW], ax});
        write_reg(REG_A_Y, {~noise[CFG_DATA_W-1:CW], ay});
        write_reg(REG_B_X, {noise[CFG_DATA_W-1:CW], bx});
        write_reg(REG_B_Y, {~noise[CFG_DATA_W-1:CW], by});
        write_reg(REG_C_X, {noise[CFG_DATA_W-1:CW], cx});
        write_reg(REG_C_Y, {~noise[CFG_DATA_W-1:CW], cy});
        write_reg(REG_FILL, rgb);
    endtask

    task automatic random_triangle(output int lo_y, output int hi_y);
        int lo_x, hi_x, t;
        int vx[3], vy[3];
        if ($urandom_range(0, 3) == 0) begin
            lo_x = 0;
            hi_x = 255;
            lo_y = 0;
            hi_y = 255;
        end else begin
            lo_x = $urandom_range(0, 255);
            hi_x = $urandom_range(lo_x, 255);
            lo_y = $urandom_range(0, 255);
            hi_y = $urandom_range(lo_y, (lo_y + 64 > 255) ? 255 : lo_y + 64);
        end
        for (int k = 0; k < 3; k++) begin
            vx[k] = $urandom_range(lo_x, hi_x);
            vy[k] = $urandom_range(lo_y, hi_y);
        end
        // mostly the filling winding, sometimes the opposite one
        if (edge_fn(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]) < 0 &&
            $urandom_range(0, 3) != 0) begin
            t = vx[1]; vx[1] = vx[2]; vx[2] = t;
            t = vy[1]; vy[1] = vy[2]; vy[2] = t;
        end
        set_triangle(CW'(vx[0]), CW'(vy[0]), CW'(vx[1]), CW'(vy[1]),
                     CW'(vx[2]), CW'(vy[2]), COLOR_W'($urandom));
        lo_y = vy[0];
        hi_y = vy[0];
        for (int k = 1; k < 3; k++) begin
            if (vy[k] < lo_y) lo_y = vy[k];
            if (vy[k] > hi_y) hi_y = vy[k];
        end
    endtask

    task automatic queue_row(input logic [CW-1:0] y);
        row_q.push_back(y);
        rows_open++;
    endtask

    task automatic wait_idle();
        while (rows_open != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    initial begin
        int lo_y, hi_y;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset configuration: a single-point box at the origin
        queue_row(8'd0);
        queue_row(8'd1);
        queue_row(8'd255);
        wait_idle();

        // full-frame triangle, all eight chunks
        set_triangle(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 24'hFFFFFF);
        write_reg(REG_NONE, CFG_DATA_W'($urandom));
        queue_row(8'd0);
        queue_row(8'd31);
        queue_row(8'd32);
        queue_row(8'd128);
        queue_row(8'd255);
        wait_idle();

        // opposite winding: no pixel fills
        set_triangle(8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 24'h000000);
        queue_row(8'd0);
        queue_row(8'd100);
        queue_row(8'd255);
        wait_idle();

        // collinear vertices
        set_triangle(8'd10, 8'd10, 8'd100, 8'd100, 8'd200, 8'd200, COLOR_W'($urandom));
        queue_row(8'd5);
        queue_row(8'd10);
        queue_row(8'd100);
        queue_row(8'd200);
        queue_row(8'd201);
        wait_idle();

        // small triangle inside one chunk
        set_triangle(8'd40, 8'd40, 8'd40, 8'd60, 8'd60, 8'd60, COLOR_W'($urandom));
        queue_row(8'd39);
        queue_row(8'd40);
        queue_row(8'd50);
        queue_row(8'd60);
        wait_idle();

        for (int p = 0; p < RANDOM_TRIANGLES; p++) begin
            random_triangle(lo_y, hi_y);
            if (p == RANDOM_TRIANGLES - 1) calm = 1'b1;
            for (int k = 0; k < ROWS_PER_TRIANGLE; k++) begin
                if ($urandom_range(0, 4) == 0)
                    queue_row(CW'($urandom_range(0, 255)));
                else
                    queue_row(CW'($urandom_range(lo_y, hi_y)));
            end
            wait_idle();
        end

        repeat (12) @(posedge aclk);
        if (expected_chunks.size() != 0) begin
            $error("%0d expected results never arrived", expected_chunks.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ter_pkg.sv
hdl/ter_cell.sv
hdl/ter_ctrl.sv
hdl/triangle_edge_rasterizer.sv
verif/testbench.sv
